[rtl/core/fpa_pkg.sv]
// Shared opcodes, status codes, stage payload type and helpers for the fixed-point ALU.
`timescale 1ns / 1ps
package fpa_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_TO_INT   = 4'd14,
    OP_FROM_INT = 4'd15
  } fpa_op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP_BITS = 4;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // front-end word: simple results plus operand magnitudes for mul and div
  typedef struct packed {
    fpa_op_t     op;
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  status;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        neg;
    logic        b_zero;
  } fpa_front_t;

  // clamp a 33-bit signed sum into 32 bits
  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? S32_MIN : S32_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf33(input logic [32:0] v);
    return v[32] != v[31];
  endfunction

endpackage

[rtl/core/fixed_point_alu.sv]
// Top level: input register, front stage, multiplier and divider pipes, output skid.
// The divider, four quotient bits per stage, sets the pipeline depth.
// Throughput: one word per cycle; a stall freezes the whole pipe.
// Reset: rst (synchronous) clears every valid bit, including output and skid valid;
// data registers are not reset.
`timescale 1ns / 1ps
module fixed_point_alu import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  s_tuser,   // req_type[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // result_value[31:0]
  output logic [2:0]  m_tuser    // compare_true[0], status[2:1]
);

  localparam int STAGES = (33 + FRAC_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int NV     = STAGES + 3;

  logic               en;
  logic [NV-1:0]      vld;
  fpa_op_t            op_r;
  logic signed [31:0] a_r, b_r;
  fpa_front_t         front_q;
  fpa_front_t         line [STAGES+1];
  logic [31:0]        mul_val, div_val;
  logic               mul_sat;
  logic [1:0]         div_st;
  logic [34:0]        sel;
  logic               take, push;
  logic [34:0]        out_w, skid_w;
  logic               skid_valid;

  assign en       = !skid_valid;
  assign s_tready = en;

  // input register and valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NV-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r <= fpa_op_t'(s_tuser);
      a_r  <= s_tdata[31:0];
      b_r  <= s_tdata[63:32];
    end
  end

  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .en(en), .op(op_r), .a(a_r), .b(b_r), .q(front_q)
  );

  fpa_mul #(.FRAC_BITS(FRAC_BITS), .DELAY(STAGES)) u_mul (
    .clk(clk), .en(en), .mag_a(front_q.mag_a), .mag_b(front_q.mag_b),
    .neg(front_q.neg), .value(mul_val), .sat(mul_sat)
  );

  fpa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .en(en), .mag_a(front_q.mag_a), .mag_b(front_q.mag_b),
    .neg(front_q.neg), .b_zero(front_q.b_zero), .value(div_val), .status(div_st)
  );

  // carry simple results alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= front_q;
      for (int i = 1; i <= STAGES; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  // pick the result source: {status, cmp, value}
  always_comb begin
    case (line[STAGES].op)
      OP_MUL:  sel = {(mul_sat ? ST_SAT : ST_OK), 1'b0, mul_val};
      OP_DIV:  sel = {div_st, 1'b0, div_val};
      default: sel = {line[STAGES].status, line[STAGES].cmp, line[STAGES].value};
    endcase
  end

  // output register with skid
  assign take = m_tvalid && m_tready;
  assign push = en && vld[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (m_tvalid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        m_tvalid <= 1'b1;
      end
    end else if (take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_w <= skid_w;
      end
    end else if (push) begin
      if (m_tvalid && !take) begin
        skid_w <= sel;
      end else begin
        out_w <= sel;
      end
    end
  end

  assign m_tdata = out_w[31:0];
  assign m_tuser = out_w[34:32];

endmodule

[rtl/core/fpa_front.sv]
// Front stage: add, sub, compares, min/max, inc/dec, int conversions, operand magnitudes.
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               en,
  input  fpa_op_t            op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output fpa_front_t         q
);

  localparam int FW = 32 + FRAC_BITS;

  logic [32:0]   sum, diff, inc, dec;
  logic [FW-1:0] wide;
  logic          wide_ovf;
  fpa_front_t    d;

  // full-width sums and shifted integer
  assign sum  = {a[31], a} + {b[31], b};
  assign diff = {a[31], a} - {b[31], b};
  assign inc  = {a[31], a} + 33'd1;
  assign dec  = {a[31], a} - 33'd1;
  assign wide = {{FRAC_BITS{a[31]}}, a} << FRAC_BITS;
  assign wide_ovf = !((&wide[FW-1:31]) || !(|wide[FW-1:31]));

  // decode the simple operations
  always_comb begin
    d        = '0;
    d.op     = op;
    d.mag_a  = a[31] ? (~a + 32'd1) : a;
    d.mag_b  = b[31] ? (~b + 32'd1) : b;
    d.neg    = a[31] ^ b[31];
    d.b_zero = (b == 32'sd0);
    unique case (op)
      OP_ADD: begin
        d.value  = sat33(sum);
        d.status = ovf33(sum) ? ST_SAT : ST_OK;
      end
      OP_SUB: begin
        d.value  = sat33(diff);
        d.status = ovf33(diff) ? ST_SAT : ST_OK;
      end
      OP_GT:  d.cmp = a > b;
      OP_LT:  d.cmp = a < b;
      OP_GE:  d.cmp = a >= b;
      OP_LE:  d.cmp = a <= b;
      OP_EQ:  d.cmp = a == b;
      OP_NE:  d.cmp = a != b;
      OP_MIN: d.value = (a < b) ? a : b;
      OP_MAX: d.value = (a > b) ? a : b;
      OP_INC: begin
        d.value  = sat33(inc);
        d.status = ovf33(inc) ? ST_SAT : ST_OK;
      end
      OP_DEC: begin
        d.value  = sat33(dec);
        d.status = ovf33(dec) ? ST_SAT : ST_OK;
      end
      OP_TO_INT: d.value = a >>> FRAC_BITS;
      OP_FROM_INT: begin
        d.value  = wide_ovf ? (a[31] ? S32_MIN : S32_MAX) : wide[31:0];
        d.status = wide_ovf ? ST_SAT : ST_OK;
      end
      default: d.value = '0;
    endcase
  end

  // hold on stall
  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

[rtl/core/fpa_mul.sv]
// Multiplier: magnitude product, rounding and saturation, then a delay to the divider depth.
`timescale 1ns / 1ps
module fpa_mul import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int DELAY     = 10
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag_a,
  input  logic [31:0] mag_b,
  input  logic        neg,
  output logic [31:0] value,
  output logic        sat
);

  logic [63:0] prod;
  logic        prod_neg;
  logic [63:0] rnd;
  logic        ovf;
  logic [31:0] val_line [DELAY];
  logic        sat_line [DELAY];

  // round half away from zero on the magnitude
  assign rnd = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign ovf = prod_neg ? (rnd > 64'h8000_0000) : (rnd > 64'h7fff_ffff);

  always_ff @(posedge clk) begin
    if (en) begin
      prod     <= mag_a * mag_b;
      prod_neg <= neg;
      val_line[0] <= ovf ? (prod_neg ? S32_MIN : S32_MAX)
                         : (prod_neg ? (~rnd[31:0] + 32'd1) : rnd[31:0]);
      sat_line[0] <= ovf;
      for (int i = 1; i < DELAY; i++) begin
        val_line[i] <= val_line[i-1];
        sat_line[i] <= sat_line[i-1];
      end
    end
  end

  assign value = val_line[DELAY-1];
  assign sat   = sat_line[DELAY-1];

endmodule

[rtl/core/fpa_div.sv]
// Divider: restoring division, DIV_STEP_BITS quotient bits per stage, then rounding and clamp.
`timescale 1ns / 1ps
module fpa_div import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag_a,
  input  logic [31:0] mag_b,
  input  logic        neg,
  input  logic        b_zero,
  output logic [31:0] value,
  output logic [1:0]  status
);

  // one extra quotient bit carries the rounding half
  localparam int QW     = 33 + FRAC_BITS;
  localparam int STAGES = (QW + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int NW     = STAGES * DIV_STEP_BITS;

  logic [31:0] rem  [STAGES];
  logic [NW-1:0] nq [STAGES];
  logic [31:0] dvs  [STAGES];
  logic        sgn  [STAGES];
  logic        zero [STAGES];

  logic [NW:0] qr;
  logic        ovf;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [31:0]   r_in;
    logic [NW-1:0] x_in;
    logic [31:0]   d_in;
    logic          neg_in;
    logic          zero_in;
    logic [31:0]   r;
    logic [NW-1:0] x;
    logic [32:0]   t;

    if (s == 0) begin : g_first
      assign r_in    = '0;
      assign x_in    = NW'(mag_a) << (FRAC_BITS + 1);
      assign d_in    = mag_b;
      assign neg_in  = neg;
      assign zero_in = b_zero;
    end else begin : g_next
      assign r_in    = rem[s-1];
      assign x_in    = nq[s-1];
      assign d_in    = dvs[s-1];
      assign neg_in  = sgn[s-1];
      assign zero_in = zero[s-1];
    end

    // shift in numerator bits, subtract where the divisor fits
    always_comb begin
      r = r_in;
      x = x_in;
      t = '0;
      for (int k = 0; k < DIV_STEP_BITS; k++) begin
        t = {r, x[NW-1]};
        x = {x[NW-2:0], 1'b0};
        if (t >= {1'b0, d_in}) begin
          r    = 32'(t - {1'b0, d_in});
          x[0] = 1'b1;
        end else begin
          r = t[31:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= r;
        nq[s]   <= x;
        dvs[s]  <= d_in;
        sgn[s]  <= neg_in;
        zero[s] <= zero_in;
      end
    end
  end

  // round the doubled quotient and clamp
  assign qr  = ({1'b0, nq[STAGES-1]} + (NW+1)'(1)) >> 1;
  assign ovf = sgn[STAGES-1] ? (qr > (NW+1)'(64'h8000_0000))
                             : (qr > (NW+1)'(64'h7fff_ffff));

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero[STAGES-1]) begin
        value  <= '0;
        status <= ST_DIV0;
      end else if (ovf) begin
        value  <= sgn[STAGES-1] ? S32_MIN : S32_MAX;
        status <= ST_SAT;
      end else begin
        value  <= sgn[STAGES-1] ? (~qr[31:0] + 32'd1) : qr[31:0];
        status <= ST_OK;
      end
    end
  end

endmodule

[rtl/core/fpa_checker.sv]
// Port-level checks for the fixed-point ALU and their bind.
`timescale 1ns / 1ps
module fpa_checker import fpa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // divide by zero reports a zero result
  a_div0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] == ST_DIV0 |-> m_tdata == 32'd0 && !m_tuser[0])
    else $error("divide by zero with nonzero result");

  // a true compare carries ok status and zero value
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK && m_tdata == 32'd0)
    else $error("compare result with stray value or status");

  // saturation lands on a bound
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] == ST_SAT |-> m_tdata == S32_MAX || m_tdata == S32_MIN)
    else $error("saturated result not at a bound");

  // reset empties the output
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tuser(m_tuser)
);

[bench/fpa_checker.sv]
// Checker for the fixed-point ALU: watches both streams, predicts each result and compares.
`timescale 1ns / 1ps
module alu_scoreboard import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [3:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic [1:0]  status;
  } alu_result_t;

  alu_result_t expected_q[$];

  // clamp a wide signed value into 32 bits, flag saturation
  function automatic logic [31:0] clamp32(input longint v, inout logic [1:0] st);
    if (v > 64'sd2147483647) begin
      st = ST_SAT;
      return S32_MAX;
    end
    if (v < -64'sd2147483648) begin
      st = ST_SAT;
      return S32_MIN;
    end
    return v[31:0];
  endfunction

  // compute the expected result of one request
  function automatic alu_result_t alu_predict(input fpa_op_t op, input logic [31:0] ra,
                                              input logic [31:0] rb);
    longint a, b, s;
    logic [63:0] ma, mb, m, n, q;
    logic neg;
    alu_result_t r;
    a = longint'(signed'(ra));
    b = longint'(signed'(rb));
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    r = '0;
    case (op)
      OP_ADD: r.value = clamp32(a + b, r.status);
      OP_SUB: r.value = clamp32(a - b, r.status);
      OP_MUL: begin
        m = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        s = neg ? -longint'(m) : longint'(m);
        r.value = clamp32(s, r.status);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.status = ST_DIV0;
        end else begin
          n = ma << FRAC_BITS;
          q = (2 * n + mb) / (2 * mb);
          s = neg ? -longint'(q) : longint'(q);
          r.value = clamp32(s, r.status);
        end
      end
      OP_GT: r.cmp = a > b;
      OP_LT: r.cmp = a < b;
      OP_GE: r.cmp = a >= b;
      OP_LE: r.cmp = a <= b;
      OP_EQ: r.cmp = a == b;
      OP_NE: r.cmp = a != b;
      OP_MIN: r.value = (a < b) ? ra : rb;
      OP_MAX: r.value = (a > b) ? ra : rb;
      OP_INC: r.value = clamp32(a + 1, r.status);
      OP_DEC: r.value = clamp32(a - 1, r.status);
      OP_TO_INT: r.value = 32'(a >>> FRAC_BITS);
      default: r.value = clamp32(a * (longint'(1) << FRAC_BITS), r.status);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  assign pending = expected_q.size();

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      expected_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", m_tdata, '0);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata !== want.value) report_mismatch("result_value", m_tdata, want.value);
          if (m_tuser[0] !== want.cmp)
            report_mismatch("compare_true", 32'(m_tuser[0]), 32'(want.cmp));
          if (m_tuser[2:1] !== want.status)
            report_mismatch("status", 32'(m_tuser[2:1]), 32'(want.status));
        end
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(alu_predict(fpa_op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]));
    end
  end

  initial errors = 0;

endmodule

[bench/tb.sv]
// Testbench top: drives requests and result back-pressure, gives the verdict.
`timescale 1ns / 1ps
module tb import fpa_pkg::*;;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY = 14;
  localparam int IDLE_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  bit          stim_done = 1'b0;
  bit          hold_off = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) u_dut (.*);

  alu_scoreboard #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

  // pick an operand biased toward boundaries and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return S32_MAX - $urandom_range(0, 2);
      1: return S32_MIN + $urandom_range(0, 2);
      2: return 32'($urandom_range(0, 4)) - 32'd2;
      3, 4: return 32'(signed'(16'($urandom())));
      default: return $urandom();
    endcase
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(input fpa_op_t op, input logic [31:0] a, input logic [31:0] b);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receiver: long hold-off once, then random stalls with calm stretches
  initial begin
    int n;
    int cyc;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (!hold_off) @(posedge clk);
    n = 0;
    while (n < 300) begin
      @(posedge clk);
      n++;
    end
    cyc = 0;
    forever begin
      m_tready <= (cyc % 512) < 128 ? 1'b1 : ($urandom_range(0, 3) != 0);
      cyc++;
      @(posedge clk);
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] edges[6];
    int gap;
    int burst;
    int w;
    edges = '{S32_MAX, S32_MIN, 32'd0, 32'd1, 32'hffff_ffff, 32'h0000_0100};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // back-pressure: keep offering while the receiver holds off
    hold_off = 1'b1;
    // directed: every op on boundary pairs, division by zero, equal min/max, mul/div/int edges
    for (int op = 0; op < 16; op++)
      send_request(fpa_op_t'(op), edges[op % 6], edges[(op + 1) % 6]);
    send_request(OP_DIV, 32'h0000_0500, 32'd0);
    send_request(OP_MIN, 32'h1234_5678, 32'h1234_5678);
    send_request(OP_MAX, 32'hfedc_ba98, 32'hfedc_ba98);
    send_request(OP_MUL, S32_MIN, S32_MIN);
    send_request(OP_DIV, S32_MAX, 32'd1);
    send_request(OP_TO_INT, 32'hffff_ff01, 32'd0);
    send_request(OP_FROM_INT, 32'hff80_0000, 32'd0);
    // random bursts with gaps
    for (int i = 0; i < 2000; i += burst) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst; k++) begin
        w = $urandom_range(0, 7);
        send_request(fpa_op_t'($urandom_range(0, 15)), pick_operand(),
                     w == 0 ? 32'd0 : pick_operand());
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY * 2) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_mul.sv
rtl/core/fpa_div.sv
rtl/core/fixed_point_alu.sv
rtl/core/fpa_checker.sv
bench/fpa_checker.sv
bench/tb.sv
